// File: rtl/dnrle_pkg.sv
// Shared types and constants of the delta nibble / run-length image encoder.
// Used by every module of the encoder; depends on nothing else.
`timescale 1ns / 1ps

package dnrle_pkg;

  localparam int PIXEL_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int THRESH_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int MAX_BYTES  = 4;
  localparam int CNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

  localparam logic [NIB_W-1:0]    ESCAPE_NIBBLE = 4'h8;
  localparam logic [BYTE_W-1:0]   END_CR        = 8'd13;
  localparam logic [BYTE_W-1:0]   END_LF        = 8'd10;
  localparam logic [BYTE_W-1:0]   RUN_MAX       = 8'd255;
  localparam logic [BYTE_W-1:0]   BLACK_START   = 8'd1;
  localparam logic [BYTE_W-1:0]   LONG_RUN_MARK = 8'd0;
  localparam logic [THRESH_W-1:0] THRESH_RESET  = 9'd128;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_WHITE_START,
    PH_RUNNING
  } run_phase_t;

  // Bytes produced by one pixel, byte 0 goes out first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 count;
  } byte_group_t;

  typedef struct packed {
    logic             free;
    logic [CNT_W-1:0] rem;
  } obuf_status_t;

endpackage

// File: rtl/dnrle_delta.sv
// Delta nibble coder: nibble packing state and the bytes produced by one pixel.
// Depends on dnrle_pkg.
`timescale 1ns / 1ps

module dnrle_delta import dnrle_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PIXEL_W-1:0] in_pixel,
  input  logic               in_last,
  input  logic               step,
  input  logic               clear,
  output byte_group_t        grp
);

  logic [PIXEL_W-1:0] prev_r;
  logic               seen_r;
  logic [NIB_W-1:0]   pend_nib_r;
  logic               pend_r;

  logic [PIXEL_W:0]   diff;
  logic               near;
  logic [NIB_W-1:0]   seq [MAX_BYTES];
  logic [CNT_W-1:0]   len;
  logic               odd;
  logic [NIB_W-1:0]   leftover;
  logic [1:0]         idx;

  always_comb begin
    diff  = {1'b0, in_pixel} - {1'b0, prev_r};
    near  = seen_r && ((diff[PIXEL_W:3] == '0) ||
                       ((diff[PIXEL_W:3] == '1) && (diff[2:0] != 3'b000)));
    if (pend_r) begin
      seq[0] = pend_nib_r;
      seq[1] = near ? diff[NIB_W-1:0] : ESCAPE_NIBBLE;
      seq[2] = in_pixel[7:4];
      seq[3] = in_pixel[3:0];
    end else begin
      seq[0] = near ? diff[NIB_W-1:0] : ESCAPE_NIBBLE;
      seq[1] = in_pixel[7:4];
      seq[2] = in_pixel[3:0];
      seq[3] = '0;
    end
    len      = {2'b00, pend_r} + (near ? 3'd1 : 3'd3);
    odd      = len[0];
    leftover = len[1] ? seq[2] : seq[0];

    grp          = '0;
    grp.bytes[0] = {seq[0], seq[1]};
    grp.bytes[1] = {seq[2], seq[3]};
    grp.count    = {1'b0, len[2:1]};
    idx          = len[2:1];
    if (in_last) begin
      if (odd) begin
        grp.bytes[idx] = {leftover, 4'h0};
        idx            = idx + 2'd1;
      end
      grp.bytes[idx]        = END_CR;
      grp.bytes[idx + 2'd1] = END_LF;
      grp.count             = {1'b0, idx} + 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      prev_r     <= '0;
      seen_r     <= 1'b0;
      pend_nib_r <= '0;
      pend_r     <= 1'b0;
    end else if (step) begin
      prev_r     <= in_pixel;
      seen_r     <= 1'b1;
      pend_r     <= odd;
      pend_nib_r <= odd ? leftover : '0;
    end
  end

endmodule

// File: rtl/dnrle_run.sv
// Run-length coder: color, run count and start phase, and the bytes of one pixel.
// Depends on dnrle_pkg.
`timescale 1ns / 1ps

module dnrle_run import dnrle_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [PIXEL_W-1:0]  in_pixel,
  input  logic                in_last,
  input  logic [THRESH_W-1:0] threshold,
  input  logic                step,
  input  logic                clear,
  output byte_group_t         grp
);

  run_phase_t        phase_r, phase_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic              white_r, white_nxt;

  logic              white;
  logic              has_first;
  logic [BYTE_W-1:0] first_byte;

  always_comb begin
    white      = {1'b0, in_pixel} >= threshold;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    white_nxt  = white_r;
    has_first  = 1'b0;
    first_byte = '0;
    case (phase_r)
      PH_FIRST: begin
        has_first  = !white;
        first_byte = BLACK_START;
        white_nxt  = white;
        cnt_nxt    = 8'd1;
        phase_nxt  = (!white || in_last) ? PH_RUNNING : PH_WHITE_START;
      end
      PH_WHITE_START: begin
        if (!white) begin
          has_first  = 1'b1;
          first_byte = BLACK_START;
          white_nxt  = 1'b0;
        end
        cnt_nxt   = 8'd2;
        phase_nxt = PH_RUNNING;
      end
      default: begin
        if (white == white_r) begin
          if (cnt_r >= RUN_MAX) begin
            has_first  = 1'b1;
            first_byte = LONG_RUN_MARK;
            cnt_nxt    = 8'd1;
          end else begin
            cnt_nxt = cnt_r + 8'd1;
          end
        end else begin
          has_first  = 1'b1;
          first_byte = cnt_r;
          white_nxt  = !white_r;
          cnt_nxt    = 8'd1;
        end
      end
    endcase

    grp = '0;
    if (has_first) begin
      grp.bytes[0] = first_byte;
      grp.bytes[1] = cnt_nxt;
    end else begin
      grp.bytes[0] = cnt_nxt;
    end
    grp.count = {2'b00, has_first} + {2'b00, in_last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= PH_FIRST;
      cnt_r   <= '0;
      white_r <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      white_r <= white_nxt;
    end
  end

endmodule

// File: rtl/dnrle_obuf.sv
// Result register: holds the bytes of one pixel and hands them out one per item.
// Depends on dnrle_pkg.
`timescale 1ns / 1ps

module dnrle_obuf import dnrle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  byte_group_t       grp,
  input  logic              grp_last,
  input  logic              load,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_code_byte,
  output logic              out_last_byte,
  output obuf_status_t      status
);

  logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_r;
  logic [CNT_W-1:0]                 rem_r;
  logic                             last_r;
  logic                             fire;

  assign out_valid     = (rem_r != '0);
  assign fire          = out_valid && !out_stall;
  assign out_code_byte = bytes_r[0];
  assign out_last_byte = last_r && (rem_r == 3'd1);
  assign status.free   = (rem_r == '0) || ((rem_r == 3'd1) && fire);
  assign status.rem    = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= grp.count;
    end else if (fire) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= grp.bytes;
      last_r  <= grp_last;
    end else if (fire) begin
      bytes_r <= bytes_r >> BYTE_W;
    end
  end

endmodule

// File: rtl/delta_nibble_rle_image_encoder_top.sv
// Top level of the delta nibble / run-length grey image encoder.
// Depends on dnrle_pkg, dnrle_delta, dnrle_run and dnrle_obuf.
//
// Pixels enter in raster order on the in_ channel (in_pixel, in_last_pixel)
// and compressed bytes leave on the out_ channel (out_code_byte, out_last_byte).
// Each channel moves an item at a clock edge where valid is high and stall low.
// The cfg_ port writes run_mode (index 0) and threshold (index 1); write it
// only while no pixel is in flight.
// A pixel is captured in an input register; from there its bytes (zero to
// four) are loaded into the result register once that register is free, and
// its first byte is offered there and leaves at an edge where out_stall is low.
// A pixel is taken every cycle while the receiver does not stall and each
// pixel yields at most one byte; pixels that yield more hold the input until
// their bytes leave; the result register gives one byte a cycle unless stalled.
// Pixels that yield no byte pass without touching the output side.
// When the receiver stalls, the result register holds its byte and the input
// register fills, then in_stall rises. Reset clears both registers and all
// coding state; after the last pixel of an image the coding state returns to
// its reset value as well.
`timescale 1ns / 1ps

module delta_nibble_rle_image_encoder_top import dnrle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_W-1:0]    in_pixel,
  input  logic                  in_last_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_code_byte,
  output logic                  out_last_byte
);

  logic                run_mode_r;
  logic [THRESH_W-1:0] threshold_r;

  logic                a_valid_r;
  logic [PIXEL_W-1:0]  a_pixel_r;
  logic                a_last_r;

  byte_group_t         delta_grp;
  byte_group_t         run_grp;
  byte_group_t         grp;
  obuf_status_t        ob_status;
  logic                take;
  logic                load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r  <= 1'b0;
      threshold_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RUN_MODE:  run_mode_r  <= cfg_data[0];
        REG_THRESHOLD: threshold_r <= cfg_data[THRESH_W-1:0];
        default:       ;
      endcase
    end
  end

  assign grp      = run_mode_r ? run_grp : delta_grp;
  assign take     = a_valid_r && ((grp.count == '0) || ob_status.free);
  assign load     = take && (grp.count != '0);
  assign in_stall = a_valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_pixel_r <= in_pixel;
      a_last_r  <= in_last_pixel;
    end
  end

  dnrle_delta u_delta (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pixel (a_pixel_r),
    .in_last  (a_last_r),
    .step     (take && !run_mode_r),
    .clear    (take && a_last_r),
    .grp      (delta_grp)
  );

  dnrle_run u_run (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pixel  (a_pixel_r),
    .in_last   (a_last_r),
    .threshold (threshold_r),
    .step      (take && run_mode_r),
    .clear     (take && a_last_r),
    .grp       (run_grp)
  );

  dnrle_obuf u_obuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .grp           (grp),
    .grp_last      (a_last_r),
    .load          (load),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_code_byte (out_code_byte),
    .out_last_byte (out_last_byte),
    .status        (ob_status)
  );

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (ob_status.rem <= 3'd1))
    else $error("result register loaded while bytes remain");

  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ob_status.rem <= 3'd4)
    else $error("result register count out of range");

  a_delta_end_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_last_r && !run_mode_r) |-> (delta_grp.count >= 3'd2))
    else $error("delta image end without CR LF");

  a_run_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_last_r && run_mode_r) |-> (run_grp.count >= 3'd1))
    else $error("run image end without final run byte");

  a_load_shows_next: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded bytes not presented");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the delta nibble / run-length grey image encoder.
// Depends on dnrle_pkg and delta_nibble_rle_image_encoder_top; it drives pixels,
// predicts the byte stream in its own encoder model and checks every output item.
`timescale 1ns / 1ps

module testbench;
  import dnrle_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 200;
  localparam int PHASE_ITEMS   = 20;
  localparam int NUM_PHASES    = 6;
  localparam bit TYPED         = 1'b1;
  localparam bit PREDICTED     = 1'b0;

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [8:0]                value;
    logic                      flag;
    logic                      is_typed;
    logic [2:0]                typed_n;
    logic [3:0][BYTE_W-1:0]    typed;
  } plan_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              last;
  } coded_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIXEL_W-1:0]    in_pixel;
  logic                  in_last_pixel;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     out_code_byte;
  logic                  out_last_byte;

  delta_nibble_rle_image_encoder_top uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Encoder model state and configuration.
  logic              mode_run;
  logic [8:0]        white_level;
  logic [7:0]        last_px;
  bit                px_seen;
  logic [3:0]        held_nib;
  bit                nib_held;
  logic [7:0]        run_len;
  bit                run_white;
  run_phase_t        run_ph;
  logic [7:0]        new_bytes[$];
  coded_byte_t       code_bytes_due[$];

  plan_row_t         plan[$];
  plan_row_t         row;
  coded_byte_t       want;
  int                errors = 0;
  int                bytes_checked = 0;
  int                pixels_sent = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                holds_asked = 0;
  int                holds_done = 0;
  int                gen_prev = 0;
  int                gen_run_left = 0;
  bit                gen_white;
  int                ph, items, len, first_run, i;
  bit                closed;
  int                send_pct_of[NUM_PHASES]  = '{0, 67, 0, 18, 0, 18};
  int                recv_pct_of[NUM_PHASES]  = '{0, 0, 67, 18, 0, 18};
  bit                mode_of[NUM_PHASES]      = '{0, 1, 0, 1, 0, 1};

  function void restart_image();
    last_px   = '0;
    px_seen   = 1'b0;
    held_nib  = '0;
    nib_held  = 1'b0;
    run_len   = '0;
    run_white = 1'b1;
    run_ph    = PH_FIRST;
  endfunction

  function void put_byte(input logic [7:0] b);
    new_bytes.push_back(b);
  endfunction

  function void put_nibble(input logic [3:0] nb);
    if (nib_held) begin
      put_byte({held_nib, nb});
      nib_held = 1'b0;
      held_nib = '0;
    end else begin
      held_nib = nb;
      nib_held = 1'b1;
    end
  endfunction

  function void encode_pixel(input logic [7:0] px, input logic lst);
    int   diff;
    logic white;
    new_bytes.delete();
    if (!mode_run) begin
      diff = int'(px) - int'(last_px);
      if (px_seen && diff > -8 && diff < 8) begin
        put_nibble(diff[3:0]);
      end else begin
        put_nibble(ESCAPE_NIBBLE);
        put_nibble(px[7:4]);
        put_nibble(px[3:0]);
      end
      last_px = px;
      px_seen = 1'b1;
      if (lst) begin
        if (nib_held) put_byte({held_nib, 4'h0});
        put_byte(END_CR);
        put_byte(END_LF);
      end
    end else begin
      white = ({1'b0, px} >= white_level);
      case (run_ph)
        PH_FIRST: begin
          if (!white) put_byte(BLACK_START);
          run_white = white;
          run_len = 8'd1;
          if (!white || lst) run_ph = PH_RUNNING;
          else run_ph = PH_WHITE_START;
        end
        PH_WHITE_START: begin
          if (!white) begin
            put_byte(BLACK_START);
            run_white = 1'b0;
          end
          run_len = 8'd2;
          run_ph = PH_RUNNING;
        end
        default: begin
          if (white == run_white) begin
            if (run_len >= RUN_MAX) begin
              put_byte(LONG_RUN_MARK);
              run_len = 8'd1;
            end else begin
              run_len++;
            end
          end else begin
            put_byte(run_len);
            run_white = !run_white;
            run_len = 8'd1;
          end
        end
      endcase
      if (lst) put_byte(run_len);
    end
    if (lst) restart_image();
  endfunction

  function void add_row(input row_kind_t k, input logic [8:0] v, input logic f,
                        input logic t, input logic [2:0] n, input logic [7:0] b0,
                        input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
    plan_row_t r;
    r.kind = k;
    r.value = v;
    r.flag = f;
    r.is_typed = t;
    r.typed_n = n;
    r.typed = {b3, b2, b1, b0};
    plan.push_back(r);
  endfunction

  function logic [8:0] pick_threshold();
    logic [8:0] t;
    case ($urandom_range(4))
      0:       t = 9'd0;
      1:       t = 9'd256;
      2:       t = 9'($urandom_range(257, 511));
      default: t = 9'($urandom_range(1, 255));
    endcase
    return t;
  endfunction

  function logic [7:0] gen_delta_pixel();
    int v;
    case ($urandom_range(9))
      0:       v = $urandom_range(255);
      1:       v = ($urandom_range(1) == 1) ? gen_prev + 8 : gen_prev - 8;
      default: v = int'($urandom_range(14)) - 7 + gen_prev;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    gen_prev = v;
    return v[7:0];
  endfunction

  function logic [7:0] gen_run_pixel();
    logic [7:0] p;
    if (gen_run_left == 0) begin
      gen_white = !gen_white;
      gen_run_left = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
    end
    gen_run_left--;
    if (white_level == 0 || white_level > 255 || (gen_run_left < 20 && $urandom_range(15) == 0))
      p = 8'($urandom_range(255));
    else if (gen_white)
      p = 8'($urandom_range(white_level, 255));
    else
      p = 8'($urandom_range(0, white_level - 1));
    return p;
  endfunction

  task automatic push_pixel(input logic [7:0] px, input logic lst, input logic use_typed,
                            input logic [2:0] typed_n, input logic [3:0][7:0] typed);
    int          k;
    coded_byte_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel      <= px;
    in_last_pixel <= lst;
    do @(posedge clk); while (in_stall !== 1'b0);
    encode_pixel(px, lst);
    if (use_typed) begin
      new_bytes.delete();
      for (k = 0; k < typed_n; k++) new_bytes.push_back(typed[k]);
    end
    for (k = 0; k < new_bytes.size(); k++) begin
      e.code = new_bytes[k];
      e.last = lst && (k == new_bytes.size() - 1);
      code_bytes_due.push_back(e);
    end
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (code_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic run_sel, input logic [8:0] level);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_RUN_MODE;
    cfg_data  <= {junk, run_sel};
    @(posedge clk);
    mode_run = run_sel;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= level;
    @(posedge clk);
    white_level = level;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_image(input int n, input bit ends, input int first_len);
    int k;
    gen_white = 1'($urandom_range(1));
    gen_run_left = first_len;
    for (k = 0; k < n; k++) begin
      push_pixel(mode_run ? gen_run_pixel() : gen_delta_pixel(), ends && (k == n - 1),
                 PREDICTED, 3'd0, '0);
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (code_bytes_due.size() == 0) begin
        $error("code_byte: expected none, actual %02h", out_code_byte);
        errors++;
      end else begin
        want = code_bytes_due.pop_front();
        bytes_checked++;
        if (out_code_byte !== want.code) begin
          $error("code_byte: expected %02h, actual %02h", want.code, out_code_byte);
          errors++;
        end
        if (out_last_byte !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, out_last_byte);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_RUN_MODE;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_pixel      <= '0;
    in_last_pixel <= 1'b0;
    mode_run      = 1'b0;
    white_level   = THRESH_RESET;
    restart_image();

    // Delta coding from reset, then run-length starts, thresholds and mode switches.
    add_row(ROW_PIXEL,  9'h000, 1'b0, TYPED,     3'd1, 8'h80, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h005, 1'b0, TYPED,     3'd1, 8'h05, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h000, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0FF, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0F8, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0F0, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0F7, 1'b1, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0AB, 1'b1, TYPED,     3'd4, 8'h8A, 8'hB0, END_CR, END_LF);
    add_row(ROW_PIXEL,  9'h012, 1'b0, TYPED,     3'd1, 8'h81, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h012, 1'b1, TYPED,     3'd3, 8'h20, END_CR, END_LF, 8'h00);
    add_row(ROW_CONFIG, 9'd128, 1'b1, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h07F, 1'b1, TYPED,     3'd2, 8'h01, 8'h01, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0FF, 1'b1, TYPED,     3'd1, 8'h01, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h080, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h000, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h000, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0FF, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0FF, 1'b1, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'd200, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'd200, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'd10,  1'b1, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_CONFIG, 9'd256, 1'b1, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h0FF, 1'b1, TYPED,     3'd2, 8'h01, 8'h01, 8'h00, 8'h00);
    add_row(ROW_CONFIG, 9'd0,   1'b1, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h000, 1'b1, TYPED,     3'd1, 8'h01, 8'h00, 8'h00, 8'h00);
    add_row(ROW_CONFIG, 9'd511, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h05A, 1'b0, TYPED,     3'd1, 8'h85, 8'h00, 8'h00, 8'h00);
    add_row(ROW_CONFIG, 9'd511, 1'b1, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h000, 1'b0, TYPED,     3'd1, 8'h01, 8'h00, 8'h00, 8'h00);
    add_row(ROW_CONFIG, 9'd511, 1'b0, PREDICTED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(ROW_PIXEL,  9'h05C, 1'b1, TYPED,     3'd3, 8'hA2, END_CR, END_LF, 8'h00);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < plan.size(); i++) begin
      row = plan[i];
      if (row.kind == ROW_CONFIG) begin
        wait_idle();
        set_config(row.flag, row.value);
      end else begin
        push_pixel(row.value[7:0], row.flag, row.is_typed, row.typed_n, row.typed);
      end
    end

    // Random images; the last image of a phase may stay open across a mode change.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      send_idle_pct  = send_pct_of[ph];
      recv_stall_pct = recv_pct_of[ph];
      set_config(mode_of[ph], (ph == 3) ? 9'($urandom_range(1, 255)) : pick_threshold());
      if (ph == 4) holds_asked++;
      items = 0;
      while (items < PHASE_ITEMS) begin
        first_run = 0;
        len = $urandom_range(1, 8);
        if (ph == 3 && items == 0) begin
          len = $urandom_range(258, 264);
          first_run = len - 2;
        end
        closed = (items + len < PHASE_ITEMS) || ($urandom_range(1) == 1);
        send_image(len, closed, first_run);
        items += len;
        if (ph == 2 && items == len) wait_idle();
      end
    end
    wait_idle();

    $display("Covered %0d pixels and %0d checked bytes in delta and run-length coding,",
             pixels_sent, bytes_checked);
    $display("including long runs, threshold extremes, open images and output back-pressure.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
